// File: rtl/rhsv_pkg.sv
// types, constants and helpers shared by the rgb to hsv pixel pipeline
`timescale 1ns / 1ps
`default_nettype none

package rhsv_pkg;

	localparam int CHAN_W   = 8;
	localparam int HUE_W    = 9;
	localparam int PCT_W    = 7;
	localparam int NUM_W    = 15;
	localparam int QUO_W    = 7;
	localparam int QBIT_W   = $clog2(QUO_W);
	localparam int HSUM_W   = 10;

	localparam logic [6:0]        HUE_MUL    = 7'd60;
	localparam logic [6:0]        PCT_MUL    = 7'd100;
	localparam logic [CHAN_W-1:0] CHAN_FULL  = 8'd255;
	localparam logic [HSUM_W-1:0] HUE_GREEN  = 10'd120;
	localparam logic [HSUM_W-1:0] HUE_BLUE   = 10'd240;
	localparam logic [HSUM_W-1:0] HUE_TURN   = 10'd360;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [PCT_W-1:0]  saturation;
		logic [PCT_W-1:0]  brightness;
		logic [CHAN_W-1:0] alpha_out;
	} hsv_t;

	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [CHAN_W-1:0] den;
		logic [QUO_W-1:0]  quo;
	} div_lane_t;

	typedef struct packed {
		sector_t           sector;
		logic              neg;
		logic              hue_zero;
		logic              sat_zero;
		logic [CHAN_W-1:0] alpha;
	} side_t;

	typedef struct packed {
		div_lane_t hue;
		div_lane_t sat;
		div_lane_t val;
		side_t     side;
	} div_word_t;

	function automatic div_lane_t div_step(div_lane_t l, logic [QBIT_W-1:0] bit_idx);
		div_lane_t        r;
		logic [NUM_W-1:0] shifted;
		r       = l;
		shifted = NUM_W'(l.den) << bit_idx;
		if (l.rem >= shifted) begin
			r.rem          = l.rem - shifted;
			r.quo[bit_idx] = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rhsv_word_if.sv
// valid/ready stream interface carrying one word of a given type
`timescale 1ns / 1ps
`default_nettype none

interface rhsv_word_if #(parameter type word_t = logic [7:0]);
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/rhsv_front.sv
// front stages: max, min, sector and signed difference, then the numerators
`timescale 1ns / 1ps
`default_nettype none

module rhsv_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire rhsv_pkg::pixel_t     in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output rhsv_pkg::div_word_t       out_data
);

	logic [rhsv_pkg::CHAN_W-1:0] hi_c;
	logic [rhsv_pkg::CHAN_W-1:0] lo_c;
	rhsv_pkg::sector_t           sector_c;
	logic signed [rhsv_pkg::CHAN_W:0] diff_c;

	logic                        valid_s1;
	logic [rhsv_pkg::CHAN_W-1:0] hi_s1;
	logic [rhsv_pkg::CHAN_W-1:0] delta_s1;
	logic [rhsv_pkg::CHAN_W-1:0] mag_s1;
	logic                        neg_s1;
	rhsv_pkg::sector_t           sector_s1;
	logic [rhsv_pkg::CHAN_W-1:0] alpha_s1;

	logic                        valid_s2;
	rhsv_pkg::div_word_t         word_s2;

	logic ready_s1;
	logic ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		hi_c = in_data.red;
		if (in_data.green > hi_c) hi_c = in_data.green;
		if (in_data.blue > hi_c) hi_c = in_data.blue;
		lo_c = in_data.red;
		if (in_data.green < lo_c) lo_c = in_data.green;
		if (in_data.blue < lo_c) lo_c = in_data.blue;
		if (hi_c == in_data.red) begin
			sector_c = rhsv_pkg::SECT_RED;
			diff_c   = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
		end else if (hi_c == in_data.green) begin
			sector_c = rhsv_pkg::SECT_GREEN;
			diff_c   = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
		end else begin
			sector_c = rhsv_pkg::SECT_BLUE;
			diff_c   = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			hi_s1     <= hi_c;
			delta_s1  <= hi_c - lo_c;
			neg_s1    <= diff_c[rhsv_pkg::CHAN_W];
			mag_s1    <= diff_c[rhsv_pkg::CHAN_W] ? rhsv_pkg::CHAN_W'(-diff_c)
			                                      : diff_c[rhsv_pkg::CHAN_W-1:0];
			sector_s1 <= sector_c;
			alpha_s1  <= in_data.alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			word_s2.hue.rem <= rhsv_pkg::NUM_W'(mag_s1) * rhsv_pkg::NUM_W'(rhsv_pkg::HUE_MUL);
			word_s2.hue.den <= delta_s1;
			word_s2.hue.quo <= '0;
			word_s2.sat.rem <= rhsv_pkg::NUM_W'(delta_s1) * rhsv_pkg::NUM_W'(rhsv_pkg::PCT_MUL);
			word_s2.sat.den <= hi_s1;
			word_s2.sat.quo <= '0;
			word_s2.val.rem <= rhsv_pkg::NUM_W'(hi_s1) * rhsv_pkg::NUM_W'(rhsv_pkg::PCT_MUL);
			word_s2.val.den <= rhsv_pkg::CHAN_FULL;
			word_s2.val.quo <= '0;
			word_s2.side.sector   <= sector_s1;
			word_s2.side.neg      <= neg_s1;
			word_s2.side.hue_zero <= (delta_s1 == '0);
			word_s2.side.sat_zero <= (hi_s1 == '0);
			word_s2.side.alpha    <= alpha_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = word_s2;

endmodule

`default_nettype wire

// File: rtl/rhsv_div.sv
// pipelined restoring divider, one quotient bit per stage on three lanes
`timescale 1ns / 1ps
`default_nettype none

module rhsv_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire rhsv_pkg::div_word_t  in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output rhsv_pkg::div_word_t       out_data
);

	localparam int N = rhsv_pkg::QUO_W;

	logic                valid_s [N];
	rhsv_pkg::div_word_t data_s  [N];
	logic                ready_c [N+1];

	assign ready_c[N] = out_ready;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [rhsv_pkg::QBIT_W-1:0] BIT = rhsv_pkg::QBIT_W'(N - 1 - k);

		logic                prev_valid;
		rhsv_pkg::div_word_t prev_data;
		rhsv_pkg::div_word_t next_data;

		if (k == 0) begin : g_first
			assign prev_valid = in_valid;
			assign prev_data  = in_data;
		end else begin : g_rest
			assign prev_valid = valid_s[k-1];
			assign prev_data  = data_s[k-1];
		end

		assign ready_c[k] = !valid_s[k] || ready_c[k+1];

		always_comb begin
			next_data     = prev_data;
			next_data.hue = rhsv_pkg::div_step(prev_data.hue, BIT);
			next_data.sat = rhsv_pkg::div_step(prev_data.sat, BIT);
			next_data.val = rhsv_pkg::div_step(prev_data.val, BIT);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (ready_c[k]) begin
				valid_s[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (ready_c[k] && prev_valid) begin
				data_s[k] <= next_data;
			end
		end
	end

	assign in_ready  = ready_c[0];
	assign out_valid = valid_s[N-1];
	assign out_data  = data_s[N-1];

endmodule

`default_nettype wire

// File: rtl/rhsv_back.sv
// final stage: hue sign, sector offset and wrap, zero cases, output register
`timescale 1ns / 1ps
`default_nettype none

module rhsv_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire rhsv_pkg::div_word_t  in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output rhsv_pkg::hsv_t            out_data
);

	logic signed [rhsv_pkg::HSUM_W-1:0] quo_c;
	logic signed [rhsv_pkg::HSUM_W-1:0] hsum_c;
	logic [rhsv_pkg::HSUM_W-1:0]        offset_c;
	rhsv_pkg::hsv_t                     hsv_c;

	logic           valid_q;
	rhsv_pkg::hsv_t hsv_q;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		quo_c = $signed(rhsv_pkg::HSUM_W'(in_data.hue.quo));
		if (in_data.side.neg) quo_c = -quo_c;
		case (in_data.side.sector)
			rhsv_pkg::SECT_GREEN: offset_c = rhsv_pkg::HUE_GREEN;
			rhsv_pkg::SECT_BLUE:  offset_c = rhsv_pkg::HUE_BLUE;
			default:              offset_c = '0;
		endcase
		hsum_c = quo_c + $signed(offset_c);
		if (hsum_c < 0) hsum_c = hsum_c + $signed(rhsv_pkg::HUE_TURN);

		hsv_c.hue        = in_data.side.hue_zero ? '0 : hsum_c[rhsv_pkg::HUE_W-1:0];
		hsv_c.saturation = in_data.side.sat_zero ? '0 : in_data.sat.quo;
		hsv_c.brightness = in_data.val.quo;
		hsv_c.alpha_out  = in_data.side.alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hsv_q <= hsv_c;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = hsv_q;

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsv_pixel.sv
// top level of the rgba to hsv pixel converter
//
// pixel is a valid/ready sink carrying red, green, blue and alpha, 8 bits each.
// result is a valid/ready source carrying hue in degrees (0..359), saturation
// and brightness in percent (0..100) and alpha_out, a copy of the input alpha.
// a word is taken at each rising clock edge with valid and ready both high.
// throughput is one pixel per clock, a new word each cycle, while not stalled.
// from pixel acceptance to result valid a word passes one stage for
// max, min and sector, one for the numerator products, seven restoring divider
// stages (one quotient bit each, the quotient width sets their number) and one
// output register for the hue offset and wrap.
// every stage has its own valid bit and a local ready, so when the receiver
// stalls the bubbles close up and the block keeps taking pixels until each
// stage holds a word; nothing is lost or repeated.
// arst_n clears all valid bits asynchronously; no result is shown after reset
// until a pixel has gone through.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel (
	input  wire  clk,
	input  wire  arst_n,
	rhsv_word_if.sink   pixel,
	rhsv_word_if.source result
);

	logic                front_valid;
	logic                front_ready;
	rhsv_pkg::div_word_t front_data;

	logic                div_valid;
	logic                div_ready;
	rhsv_pkg::div_word_t div_data;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.in_data   (pixel.data),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	rhsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	rhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule

`default_nettype wire

// File: sim/rgb_to_hsv_pixel_test.sv
// self-checking bench for the rgba to hsv pixel converter with random stalls on both sides
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_test;

	localparam int LONG_HOLD = 80;
	localparam int RANDOM_PIXELS = 1000;
	localparam int FIELD_W = rhsv_pkg::CHAN_W + 1;

	logic clk;
	logic arst_n;

	rhsv_word_if #(.word_t(rhsv_pkg::pixel_t)) pixel_bus ();
	rhsv_word_if #(.word_t(rhsv_pkg::hsv_t))   result_bus ();

	rgb_to_hsv_pixel u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_bus),
		.result (result_bus)
	);

	rhsv_pkg::pixel_t pending_pixels[$];
	rhsv_pkg::hsv_t   expected_hsv[$];
	rhsv_pkg::hsv_t   want;
	int     fail_count = 0;
	int     send_wait;
	bit     send_steady;
	int     recv_wait;
	bit     recv_steady;
	int     words_taken;
	int     next_wait;

	function automatic rhsv_pkg::pixel_t make_pixel(int r, int g, int b, int a);
		rhsv_pkg::pixel_t px;
		px.red   = r[7:0];
		px.green = g[7:0];
		px.blue  = b[7:0];
		px.alpha = a[7:0];
		return px;
	endfunction

	// base plus a small offset, kept inside the channel range
	function automatic int near(int base);
		int v;
		v = base + $urandom_range(0, 6) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v;
	endfunction

	function automatic rhsv_pkg::hsv_t hsv_of_pixel(rhsv_pkg::pixel_t px);
		rhsv_pkg::hsv_t    o;
		rhsv_pkg::sector_t sect;
		int      r;
		int      g;
		int      b;
		int      hi;
		int      lo;
		int      delta;
		int      h;
		r  = px.red;
		g  = px.green;
		b  = px.blue;
		hi = r;
		lo = r;
		sect = rhsv_pkg::SECT_RED;
		if (g > hi) begin
			hi   = g;
			sect = rhsv_pkg::SECT_GREEN;
		end
		if (b > hi) begin
			hi   = b;
			sect = rhsv_pkg::SECT_BLUE;
		end
		if (g < lo)
			lo = g;
		if (b < lo)
			lo = b;
		delta = hi - lo;
		h = 0;
		if (delta > 0) begin
			case (sect)
				rhsv_pkg::SECT_RED:   h = (60 * (g - b)) / delta;
				rhsv_pkg::SECT_GREEN: h = (60 * (b - r)) / delta + 120;
				default:              h = (60 * (r - g)) / delta + 240;
			endcase
			if (h < 0)
				h += 360;
		end
		o.hue        = rhsv_pkg::HUE_W'(h);
		o.saturation = (hi > 0) ? rhsv_pkg::PCT_W'((delta * 100) / hi) : '0;
		o.brightness = rhsv_pkg::PCT_W'((hi * 100) / 255);
		o.alpha_out  = px.alpha;
		return o;
	endfunction

	task automatic compare_field(string name, logic [FIELD_W-1:0] exp_v,
			logic [FIELD_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bus.valid <= 1'b0;
			pixel_bus.data  <= '0;
			send_wait       <= 0;
			send_steady     <= 1'b0;
		end else if (!pixel_bus.valid || pixel_bus.ready) begin
			if (pixel_bus.valid)
				expected_hsv.push_back(hsv_of_pixel(pixel_bus.data));
			if (send_wait > 0) begin
				send_wait       <= send_wait - 1;
				pixel_bus.valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				pixel_bus.data  <= pending_pixels.pop_front();
				pixel_bus.valid <= 1'b1;
				send_wait       <= send_steady ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 39) == 0)
					send_steady <= !send_steady;
			end else begin
				pixel_bus.valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			recv_wait        <= 0;
			recv_steady      <= 1'b0;
			words_taken      <= 0;
		end else if (result_bus.valid && result_bus.ready) begin
			words_taken <= words_taken + 1;
			if (expected_hsv.size() == 0) begin
				$error("result word with nothing expected: hue %0d", result_bus.data.hue);
				fail_count++;
			end else begin
				want = expected_hsv.pop_front();
				compare_field("hue", FIELD_W'(want.hue), FIELD_W'(result_bus.data.hue));
				compare_field("saturation", FIELD_W'(want.saturation),
					FIELD_W'(result_bus.data.saturation));
				compare_field("brightness", FIELD_W'(want.brightness),
					FIELD_W'(result_bus.data.brightness));
				compare_field("alpha_out", FIELD_W'(want.alpha_out),
					FIELD_W'(result_bus.data.alpha_out));
			end
			// long hold-off so the pipeline fills and stalls the pixel side
			if (words_taken + 1 == 300 || words_taken + 1 == 700)
				next_wait = LONG_HOLD;
			else
				next_wait = recv_steady ? 0 : $urandom_range(0, 3);
			if (next_wait > 0) begin
				result_bus.ready <= 1'b0;
				recv_wait        <= next_wait - 1;
			end
			if ($urandom_range(0, 39) == 0)
				recv_steady <= !recv_steady;
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int v;
		int o;
		rhsv_pkg::pixel_t px;
		arst_n = 1'b0;

		// black, white, grey and primaries
		pending_pixels.push_back(make_pixel(0, 0, 0, 0));
		pending_pixels.push_back(make_pixel(255, 255, 255, 255));
		pending_pixels.push_back(make_pixel(128, 128, 128, 8'hAA));
		pending_pixels.push_back(make_pixel(1, 1, 1, 8'h55));
		pending_pixels.push_back(make_pixel(255, 0, 0, 1));
		pending_pixels.push_back(make_pixel(0, 255, 0, 128));
		pending_pixels.push_back(make_pixel(0, 0, 255, 254));
		// ties for the largest channel
		pending_pixels.push_back(make_pixel(255, 255, 0, 0));
		pending_pixels.push_back(make_pixel(0, 255, 255, 255));
		pending_pixels.push_back(make_pixel(255, 0, 255, 17));
		pending_pixels.push_back(make_pixel(200, 200, 199, 3));
		pending_pixels.push_back(make_pixel(10, 200, 200, 4));
		// red sector wrapping below zero, and smallest nonzero deltas
		pending_pixels.push_back(make_pixel(255, 0, 100, 5));
		pending_pixels.push_back(make_pixel(255, 0, 254, 6));
		pending_pixels.push_back(make_pixel(1, 0, 0, 7));
		pending_pixels.push_back(make_pixel(0, 1, 0, 8));
		pending_pixels.push_back(make_pixel(0, 0, 1, 9));
		pending_pixels.push_back(make_pixel(255, 254, 254, 10));
		pending_pixels.push_back(make_pixel(254, 255, 255, 11));
		pending_pixels.push_back(make_pixel(100, 0, 255, 12));
		pending_pixels.push_back(make_pixel(0, 100, 255, 13));
		pending_pixels.push_back(make_pixel(37, 254, 3, 14));

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			case ($urandom_range(0, 4))
				0: px = rhsv_pkg::pixel_t'($urandom());
				1: begin
					v  = $urandom_range(0, 255);
					px = make_pixel(v, v, v, $urandom_range(0, 255));
				end
				2: begin
					v  = $urandom_range(0, 255);
					px = make_pixel(near(v), near(v), near(v), $urandom_range(0, 255));
				end
				3: begin
					v = $urandom_range(0, 255);
					o = $urandom_range(0, v);
					case ($urandom_range(0, 2))
						0:       px = make_pixel(v, v, o, $urandom_range(0, 255));
						1:       px = make_pixel(v, o, v, $urandom_range(0, 255));
						default: px = make_pixel(o, v, v, $urandom_range(0, 255));
					endcase
				end
				default: begin
					px = rhsv_pkg::pixel_t'($urandom());
					if ($urandom_range(0, 1))
						px.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					if ($urandom_range(0, 1))
						px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					if ($urandom_range(0, 1))
						px.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end
			endcase
			pending_pixels.push_back(px);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_pixels.size() > 0 || pixel_bus.valid || expected_hsv.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
rtl/rhsv_pkg.sv
rtl/rhsv_word_if.sv
rtl/rhsv_front.sv
rtl/rhsv_div.sv
rtl/rhsv_back.sv
rtl/rgb_to_hsv_pixel.sv
sim/rgb_to_hsv_pixel_test.sv
